// ===== hdl/gmmc_pkg.sv =====
// ----------------------------------------------------------------------------
// gmmc_pkg: shared definitions for the gapped motif match counter
// Field widths, character codes, mode codes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package gmmc_pkg;

  // Parameter defaults
  localparam int MAX_GAP_DEF    = 10;
  localparam int COUNT_BITS_DEF = 27;

  // Fixed field widths
  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int GI_W   = 4;
  // in_tdata carries character and gap_index, padded to whole bytes
  localparam int IN_DW  = ((CHAR_W + GI_W + 7) / 8) * 8;

  // Motif is "tgca"; a matching window holds 8 motif characters plus the gap
  localparam int MOTIF_PAIR_LEN = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_T    = 8'h74;
  localparam logic [CHAR_W-1:0] CH_G    = 8'h67;
  localparam logic [CHAR_W-1:0] CH_C    = 8'h63;
  localparam logic [CHAR_W-1:0] CH_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_TAB  = 8'h09;

  // Beat modes carried on tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_FEED  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gmmc_match.sv =====
// ----------------------------------------------------------------------------
// gmmc_match: per-gap motif pair detector
// Looks at the shifted character window and flags every gap length for which
// "tgca", gap characters, "tgca" ends at the newest character, the window is
// long enough and holds no digit.
// ----------------------------------------------------------------------------
`default_nettype none

module gmmc_match #(
  parameter int MAX_GAP = gmmc_pkg::MAX_GAP_DEF,
  localparam int NG     = MAX_GAP + 1,
  localparam int WL     = MAX_GAP + gmmc_pkg::MOTIF_PAIR_LEN,
  localparam int SW     = $clog2(WL + 1)
) (
  input  wire logic [WL-1:0][gmmc_pkg::CHAR_W-1:0] win_i,   // index 0 newest
  input  wire logic [SW-1:0]                       seen_i,
  input  wire logic [SW-1:0]                       since_i,
  output logic      [NG-1:0]                       hit_o
);

  // Motif ending at the newest character
  logic tail_hit;
  assign tail_hit = (win_i[3] == gmmc_pkg::CH_T) && (win_i[2] == gmmc_pkg::CH_G) &&
                    (win_i[1] == gmmc_pkg::CH_C) && (win_i[0] == gmmc_pkg::CH_A);

  // One leading-motif compare and length check per gap, all in parallel
  for (genvar g = 0; g < NG; g++) begin : g_gap
    localparam int BK  = 4 + g;
    localparam int LEN = gmmc_pkg::MOTIF_PAIR_LEN + g;
    logic head_hit;
    assign head_hit = (win_i[BK+3] == gmmc_pkg::CH_T) && (win_i[BK+2] == gmmc_pkg::CH_G) &&
                      (win_i[BK+1] == gmmc_pkg::CH_C) && (win_i[BK]   == gmmc_pkg::CH_A);
    assign hit_o[g] = tail_hit && head_hit &&
                      (seen_i >= SW'(LEN)) && (since_i >= SW'(LEN));
  end

endmodule

`default_nettype wire

// ===== hdl/gapped_motif_match_counter_top.sv =====
// Path: input beat to result beat through the input register, then the result register.
// Throughput: one beat per cycle while out_tready does not hold the result; every mode, including clear, is one beat.
// The per-gap compare and counter update for a character run in parallel in one stage.
// Reset (rst_n low, synchronous): window and counters zero, fill count zero,
// digit-free run saturated, both pipeline registers empty. No clearing pass.
// ----------------------------------------------------------------------------
// gapped_motif_match_counter_top: gapped DNA motif match counter
// Streams characters, reports a per-gap match mask and keeps saturating
// per-gap match counters that can be read back or cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module gapped_motif_match_counter_top #(
  parameter int MAX_GAP    = gmmc_pkg::MAX_GAP_DEF,
  parameter int COUNT_BITS = gmmc_pkg::COUNT_BITS_DEF,
  localparam int NG        = MAX_GAP + 1,
  localparam int OUT_DW    = ((NG + COUNT_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [gmmc_pkg::IN_DW-1:0]    in_tdata,   // [7:0] character, [11:8] gap_index
  input  wire logic [gmmc_pkg::MODE_W-1:0]   in_tuser,   // mode
  // Result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [OUT_DW-1:0]             out_tdata   // match_mask, then count
);

  localparam int CW = gmmc_pkg::CHAR_W;
  localparam int WL = MAX_GAP + gmmc_pkg::MOTIF_PAIR_LEN;
  localparam int SW = $clog2(WL + 1);
  localparam logic [SW-1:0]         WL_SW     = SW'(WL);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Input register
  logic                     s1_valid_r, s1_valid_nxt;
  gmmc_pkg::mode_t          s1_mode_r;
  logic [CW-1:0]            s1_char_r;
  logic [gmmc_pkg::GI_W-1:0] s1_gi_r;

  // State
  logic [WL-1:0][CW-1:0]    win_r, win_nxt;
  logic [SW-1:0]            seen_r, seen_nxt;
  logic [SW-1:0]            since_r, since_nxt;
  logic [COUNT_BITS-1:0]    counts_r [NG];
  logic [COUNT_BITS-1:0]    counts_nxt [NG];

  // Result register
  logic                     out_valid_r, out_valid_nxt;
  logic [NG-1:0]            out_mask_r, out_mask_nxt;
  logic [COUNT_BITS-1:0]    out_cnt_r, out_cnt_nxt;

  logic in_fire, s2_ready, proc;

  // Handshake
  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign proc      = s1_valid_r && s2_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= gmmc_pkg::mode_t'(in_tuser);
      s1_char_r <= in_tdata[CW-1:0];
      s1_gi_r   <= in_tdata[CW +: gmmc_pkg::GI_W];
    end
  end

  // Window after taking the current character, with updated run lengths
  logic [WL-1:0][CW-1:0] win_shift;
  logic [SW-1:0]         seen_inc, since_inc;
  logic [NG-1:0]         hit_mask;

  if (WL > 1) begin : g_shift
    assign win_shift = {win_r[WL-2:0], s1_char_r};
  end else begin : g_noshift
    assign win_shift = s1_char_r;
  end

  assign seen_inc  = (seen_r < WL_SW) ? seen_r + 1'b1 : seen_r;
  assign since_inc = gmmc_pkg::is_digit(s1_char_r) ? '0 :
                     (since_r < WL_SW) ? since_r + 1'b1 : since_r;

  gmmc_match #(
    .MAX_GAP (MAX_GAP)
  ) u_match (
    .win_i   (win_shift),
    .seen_i  (seen_inc),
    .since_i (since_inc),
    .hit_o   (hit_mask)
  );

  // Per-beat processing
  always_comb begin
    win_nxt      = win_r;
    seen_nxt     = seen_r;
    since_nxt    = since_r;
    counts_nxt   = counts_r;
    out_mask_nxt = out_mask_r;
    out_cnt_nxt  = out_cnt_r;
    if (proc) begin
      out_mask_nxt = '0;
      out_cnt_nxt  = '0;
      case (s1_mode_r)
        gmmc_pkg::MODE_FEED: begin
          if (s1_char_r != gmmc_pkg::CH_TAB) begin
            win_nxt      = win_shift;
            seen_nxt     = seen_inc;
            since_nxt    = since_inc;
            out_mask_nxt = hit_mask;
            for (int g = 0; g < NG; g++) begin
              if (hit_mask[g] && (counts_r[g] != COUNT_MAX)) begin
                counts_nxt[g] = counts_r[g] + 1'b1;
              end
            end
          end
        end
        gmmc_pkg::MODE_READ: begin
          for (int g = 0; g < NG; g++) begin
            if (32'(s1_gi_r) == g) begin
              out_cnt_nxt = counts_r[g];
            end
          end
        end
        gmmc_pkg::MODE_CLEAR: begin
          win_nxt   = '0;
          seen_nxt  = '0;
          since_nxt = WL_SW;
          for (int g = 0; g < NG; g++) begin
            counts_nxt[g] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (proc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      seen_r      <= '0;
      since_r     <= WL_SW;
      out_valid_r <= 1'b0;
      for (int g = 0; g < NG; g++) begin
        counts_r[g] <= '0;
      end
    end else begin
      win_r       <= win_nxt;
      seen_r      <= seen_nxt;
      since_r     <= since_nxt;
      out_valid_r <= out_valid_nxt;
      counts_r    <= counts_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_mask_r <= out_mask_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata                  = '0;
    out_tdata[NG-1:0]          = out_mask_r;
    out_tdata[NG +: COUNT_BITS] = out_cnt_r;
  end

  // Checks
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= WL_SW)
    else $error("fill count beyond window length");

  a_since_bound: assert property (@(posedge clk) disable iff (!rst_n)
    since_r <= WL_SW)
    else $error("digit-free run beyond window length");

  a_mask_or_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_mask_r == '0 || out_cnt_r == '0))
    else $error("result carries both a match mask and a count");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s1_mode_r == gmmc_pkg::MODE_CLEAR) |=>
      (seen_r == '0 && since_r == WL_SW && out_mask_r == '0 && out_cnt_r == '0))
    else $error("clear beat did not reset window state");

  a_mask_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && hit_mask != '0) |-> (seen_inc >= SW'(gmmc_pkg::MOTIF_PAIR_LEN)))
    else $error("match flagged before window filled");

endmodule

`default_nettype wire
